>>> rtl/core/fwpc_pkg.sv
// Shared types and constants of the flash word program controller.
// Holds the register codes, command codes, sequencer states and fixed field widths.
// No dependencies; the address decode, the top level and the bench refer to it by scoped names.
package fwpc_pkg;

  // Fixed widths of the register block.
  localparam int ADDR_W       = 16;
  localparam int BYTE_W       = 8;
  localparam int WORD_W       = 32;
  localparam int EPAGE_W      = 7;
  localparam int PAGE_CNT_W   = 11;
  localparam int WORD_CNT_W   = 4;
  localparam int LOCK_BITS    = 128;
  localparam int LOCK_IDX_W   = 7;
  localparam int LOCK_ROW_W   = 32;
  localparam int LOCK_WORDS   = 4;

  // Saturation points of the write counters.
  localparam logic [PAGE_CNT_W-1:0] PAGE_CNT_MAX = 11'h7FF;
  localparam logic [WORD_CNT_W-1:0] WORD_CNT_MAX = 4'hF;

  // Control register bit positions.
  localparam int CTRL_ERASE_BIT = 0;
  localparam int CTRL_WEN_BIT   = 1;

  // Byte count at which a word is complete.
  localparam logic [1:0] LAST_BYTE = 2'd3;

  // Register selected by an input beat.
  localparam logic [1:0] OP_ADDR_HI = 2'd0;
  localparam logic [1:0] OP_ADDR_LO = 2'd1;
  localparam logic [1:0] OP_CTRL    = 2'd2;
  localparam logic [1:0] OP_DATA    = 2'd3;

  // Flash command reported with a result.
  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_PROGRAM = 2'd1;
  localparam logic [1:0] CMD_ERASE   = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_MODIFY,
    ST_SWEEP,
    ST_RESPOND
  } state_t;

  // Work still pending when the address decode finishes.
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PROGRAM,
    ACT_ERASE
  } act_t;

endpackage

>>> rtl/core/fwpc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the page and word write counters; depends on nothing.
module fwpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/fwpc_addr_decode.sv
// Three-stage address decode: word index (address mod array size) and page index.
// Divisions by the constant sizes use exact reciprocal multiplies.
// Depends on fwpc_pkg for the address width.
module fwpc_addr_decode #(
  parameter int PAGES          = 128,
  parameter int WORDS_PER_PAGE = 512,
  localparam int TOTAL = PAGES * WORDS_PER_PAGE,
  localparam int WAW   = $clog2(TOTAL),
  localparam int PW    = $clog2(PAGES)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [fwpc_pkg::ADDR_W-1:0] x,
  output logic                       done,
  output logic [PW-1:0]              page,
  output logic [WAW-1:0]             wi
);

  localparam int AW     = fwpc_pkg::ADDR_W;
  localparam int KW     = $clog2(WORDS_PER_PAGE);
  // Reciprocal of the array size for a 16-bit dividend.
  localparam int S1     = AW + WAW;
  localparam longint M1 = ((longint'(1) << S1) + longint'(TOTAL) - 1) / longint'(TOTAL);
  localparam int M1_W   = AW + 1;
  localparam int P1_W   = AW + M1_W;
  localparam int T_W    = AW + 1 - WAW;
  // Reciprocal of the page size for a word-index dividend.
  localparam int S2     = WAW + KW;
  localparam longint M2 = ((longint'(1) << S2) + longint'(WORDS_PER_PAGE) - 1)
                          / longint'(WORDS_PER_PAGE);
  localparam int P2_W   = 2 * WAW + 1;

  logic [P1_W-1:0] prod1;
  logic [T_W-1:0]  t_r;
  logic [AW-1:0]   x_r;
  logic            v1_r;
  logic [AW:0]     diff;
  logic [WAW-1:0]  wi2_r;
  logic            v2_r;
  logic [P2_W-1:0] prod2;
  logic [PW-1:0]   page_r;
  logic [WAW-1:0]  wi3_r;
  logic            done_r;

  // Stage 1: quotient by the array size.
  assign prod1 = P1_W'(x) * P1_W'(M1);

  // Stage 2: remainder gives the word index.
  assign diff = {1'b0, x_r} - ((AW + 1)'(t_r) * (AW + 1)'(TOTAL));

  // Stage 3: page index of the word index.
  assign prod2 = P2_W'(wi2_r) * P2_W'(M2);

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= go;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  // Stage data; held between decodes.
  always_ff @(posedge clk) begin
    if (go) begin
      t_r <= prod1[S1 +: T_W];
      x_r <= x;
    end
    if (v1_r) begin
      wi2_r <= diff[WAW-1:0];
    end
    if (v2_r) begin
      page_r <= prod2[S2 +: PW];
      wi3_r  <= wi2_r;
    end
  end

  assign done = done_r;
  assign page = page_r;
  assign wi   = wi3_r;

endmodule

>>> rtl/core/flash_word_program_controller_unit.sv
// Top level of the flash word program controller: register write sequencer,
// write-count memories and page-lock bits.
// Depends on fwpc_pkg, fwpc_ram and fwpc_addr_decode.
//
// Usage: one register write per input beat (in_operation selects address high,
// address low, control or data byte; in_data_byte is the value). A beat is taken
// when start is high and busy is low. Every beat produces exactly one result,
// shown for one cycle with out_strobe; the receiver cannot hold it off.
// The interval from the accept edge to the edge that takes the result spans, for
// address, control and refused or partial data writes, the decode pipeline,
// ST_RESPOND and the output registers; the fourth data byte (word program, which
// reads and writes back both count memories) adds ST_MODIFY, and a page erase
// adds ST_SWEEP, which clears the page's word counts one entry per cycle, and a
// second decode. busy drops in the cycle the strobe shows, so the next beat may
// be taken there and beats follow each other at those same intervals.
// The address decode is a reciprocal-multiply pipeline run once per beat
// (twice for an erase). After reset the block stays busy while it clears both
// count memories one entry per cycle.
module flash_word_program_controller_unit #(
  parameter int PAGES            = 128,
  parameter int WORDS_PER_PAGE   = 512,
  parameter int PAGE_WRITE_LIMIT = 1024,
  parameter int WORD_WRITE_LIMIT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_data_byte,
  output logic        out_strobe,
  output logic [1:0]  out_command,
  output logic [15:0] out_word_address,
  output logic [31:0] out_word_data,
  output logic [6:0]  out_erase_page,
  output logic        out_page_limit_error,
  output logic        out_word_limit_error,
  output logic        out_write_refused,
  output logic        out_page_locked,
  output logic [1:0]  out_bytes_held
);

  localparam int TOTAL = PAGES * WORDS_PER_PAGE;
  localparam int WAW   = $clog2(TOTAL);
  localparam int PW    = $clog2(PAGES);
  localparam int KW    = $clog2(WORDS_PER_PAGE);
  localparam int AW    = fwpc_pkg::ADDR_W;
  localparam int PCW   = fwpc_pkg::PAGE_CNT_W;
  localparam int WCW   = fwpc_pkg::WORD_CNT_W;

  // Sequencer and register block state.
  fwpc_pkg::state_t              state_r, state_nxt;
  fwpc_pkg::act_t                act_r, act_nxt;
  logic [7:0]                    addr_hi_r, addr_hi_nxt;
  logic [7:0]                    addr_lo_r, addr_lo_nxt;
  logic                          wmode_r, wmode_nxt;
  logic [1:0]                    bcnt_r, bcnt_nxt;
  logic [31:0]                   gather_r, gather_nxt;
  logic [fwpc_pkg::LOCK_BITS-1:0] lock_r, lock_nxt;
  logic [WAW-1:0]                clr_r, clr_nxt;
  logic [WAW-1:0]                base_r, base_nxt;
  logic [KW-1:0]                 k_r, k_nxt;

  // Result being built.
  logic [1:0]  res_cmd_r, res_cmd_nxt;
  logic [15:0] res_addr_r, res_addr_nxt;
  logic [31:0] res_data_r, res_data_nxt;
  logic [6:0]  res_ep_r, res_ep_nxt;
  logic        res_perr_r, res_perr_nxt;
  logic        res_werr_r, res_werr_nxt;
  logic        res_ref_r, res_ref_nxt;

  // Output registers.
  logic        out_strobe_r, out_strobe_nxt;
  logic [1:0]  out_cmd_r, out_cmd_nxt;
  logic [15:0] out_addr_r, out_addr_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic [6:0]  out_ep_r, out_ep_nxt;
  logic        out_perr_r, out_perr_nxt;
  logic        out_werr_r, out_werr_nxt;
  logic        out_ref_r, out_ref_nxt;
  logic        out_lock_r, out_lock_nxt;
  logic [1:0]  out_bh_r, out_bh_nxt;

  // Decode unit and memory ports.
  logic           dec_go;
  logic [AW-1:0]  dec_x;
  logic           dec_done;
  logic [PW-1:0]  dec_page;
  logic [WAW-1:0] dec_wi;
  logic           pc_we;
  logic [PW-1:0]  pc_waddr;
  logic [PCW-1:0] pc_wdata, pc_rdata, pc_new;
  logic           wc_we;
  logic [WAW-1:0] wc_waddr;
  logic [WCW-1:0] wc_wdata, wc_rdata, wc_new;

  logic           accept;
  logic [AW-1:0]  cur_addr;
  logic [AW-1:0]  erase_x;
  logic [1:0]     lock_row;

  assign accept   = start && !busy;
  assign busy     = (state_r != fwpc_pkg::ST_IDLE);
  assign cur_addr = {addr_hi_r, addr_lo_r};
  assign erase_x  = AW'(AW'(addr_hi_r[7:1]) * AW'(WORDS_PER_PAGE));
  assign lock_row = ~dec_wi[1:0];

  // Saturating counts for a word program.
  assign pc_new = (pc_rdata == fwpc_pkg::PAGE_CNT_MAX) ? pc_rdata : pc_rdata + PCW'(1);
  assign wc_new = (wc_rdata == fwpc_pkg::WORD_CNT_MAX) ? wc_rdata : wc_rdata + WCW'(1);

  fwpc_addr_decode #(
    .PAGES          (PAGES),
    .WORDS_PER_PAGE (WORDS_PER_PAGE)
  ) u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (dec_go),
    .x     (dec_x),
    .done  (dec_done),
    .page  (dec_page),
    .wi    (dec_wi)
  );

  // Per-page write counts.
  fwpc_ram #(
    .WIDTH (PCW),
    .DEPTH (PAGES)
  ) u_page_cnt (
    .clk   (clk),
    .we    (pc_we),
    .waddr (pc_waddr),
    .wdata (pc_wdata),
    .raddr (dec_page),
    .rdata (pc_rdata)
  );

  // Per-word write counts.
  fwpc_ram #(
    .WIDTH (WCW),
    .DEPTH (TOTAL)
  ) u_word_cnt (
    .clk   (clk),
    .we    (wc_we),
    .waddr (wc_waddr),
    .wdata (wc_wdata),
    .raddr (dec_wi),
    .rdata (wc_rdata)
  );

  // Next state, register updates and memory controls.
  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    addr_hi_nxt    = addr_hi_r;
    addr_lo_nxt    = addr_lo_r;
    wmode_nxt      = wmode_r;
    bcnt_nxt       = bcnt_r;
    gather_nxt     = gather_r;
    lock_nxt       = lock_r;
    clr_nxt        = clr_r;
    base_nxt       = base_r;
    k_nxt          = k_r;
    res_cmd_nxt    = res_cmd_r;
    res_addr_nxt   = res_addr_r;
    res_data_nxt   = res_data_r;
    res_ep_nxt     = res_ep_r;
    res_perr_nxt   = res_perr_r;
    res_werr_nxt   = res_werr_r;
    res_ref_nxt    = res_ref_r;
    out_strobe_nxt = 1'b0;
    out_cmd_nxt    = out_cmd_r;
    out_addr_nxt   = out_addr_r;
    out_data_nxt   = out_data_r;
    out_ep_nxt     = out_ep_r;
    out_perr_nxt   = out_perr_r;
    out_werr_nxt   = out_werr_r;
    out_ref_nxt    = out_ref_r;
    out_lock_nxt   = out_lock_r;
    out_bh_nxt     = out_bh_r;
    dec_go         = 1'b0;
    dec_x          = cur_addr;
    pc_we          = 1'b0;
    pc_waddr       = dec_page;
    pc_wdata       = '0;
    wc_we          = 1'b0;
    wc_waddr       = dec_wi;
    wc_wdata       = '0;

    unique case (state_r)
      // Clearing pass over both count memories after reset.
      fwpc_pkg::ST_CLEAR: begin
        wc_we    = 1'b1;
        wc_waddr = clr_r;
        if (clr_r < WAW'(PAGES)) begin
          pc_we    = 1'b1;
          pc_waddr = clr_r[PW-1:0];
        end
        if (clr_r == WAW'(TOTAL - 1)) begin
          state_nxt = fwpc_pkg::ST_IDLE;
        end else begin
          clr_nxt = clr_r + WAW'(1);
        end
      end

      // Take a register write and start the address decode.
      fwpc_pkg::ST_IDLE: begin
        if (start) begin
          act_nxt      = fwpc_pkg::ACT_NONE;
          res_cmd_nxt  = fwpc_pkg::CMD_NONE;
          res_addr_nxt = '0;
          res_data_nxt = '0;
          res_ep_nxt   = '0;
          res_perr_nxt = 1'b0;
          res_werr_nxt = 1'b0;
          res_ref_nxt  = 1'b0;
          unique case (in_operation)
            fwpc_pkg::OP_ADDR_HI: addr_hi_nxt = in_data_byte;
            fwpc_pkg::OP_ADDR_LO: addr_lo_nxt = in_data_byte;
            fwpc_pkg::OP_CTRL: begin
              if (in_data_byte[fwpc_pkg::CTRL_ERASE_BIT]) begin
                act_nxt     = fwpc_pkg::ACT_ERASE;
                res_cmd_nxt = fwpc_pkg::CMD_ERASE;
                res_ep_nxt  = addr_hi_r[7:1];
              end
              wmode_nxt = in_data_byte[fwpc_pkg::CTRL_WEN_BIT];
            end
            fwpc_pkg::OP_DATA: begin
              if (!wmode_r) begin
                res_ref_nxt = 1'b1;
              end else begin
                if (bcnt_r == 2'd0) begin
                  gather_nxt = '0;
                end
                gather_nxt[8*bcnt_r +: 8] = in_data_byte;
                if (bcnt_r == fwpc_pkg::LAST_BYTE) begin
                  bcnt_nxt     = 2'd0;
                  act_nxt      = fwpc_pkg::ACT_PROGRAM;
                  res_cmd_nxt  = fwpc_pkg::CMD_PROGRAM;
                  res_addr_nxt = cur_addr;
                  res_data_nxt = gather_nxt;
                end else begin
                  bcnt_nxt = bcnt_r + 2'd1;
                end
              end
            end
            default: ;
          endcase
          dec_go    = 1'b1;
          dec_x     = (act_nxt == fwpc_pkg::ACT_ERASE) ? erase_x
                                                       : {addr_hi_nxt, addr_lo_nxt};
          state_nxt = fwpc_pkg::ST_DECODE;
        end
      end

      // Wait for the decode, then read, erase or report.
      fwpc_pkg::ST_DECODE: begin
        if (dec_done) begin
          unique case (act_r)
            fwpc_pkg::ACT_PROGRAM: state_nxt = fwpc_pkg::ST_MODIFY;
            fwpc_pkg::ACT_ERASE: begin
              pc_we     = 1'b1;
              base_nxt  = dec_wi;
              k_nxt     = '0;
              state_nxt = fwpc_pkg::ST_SWEEP;
            end
            default: state_nxt = fwpc_pkg::ST_RESPOND;
          endcase
        end
      end

      // Count read data is valid: write back, flag limits, update locks.
      fwpc_pkg::ST_MODIFY: begin
        pc_we        = 1'b1;
        pc_wdata     = pc_new;
        wc_we        = 1'b1;
        wc_wdata     = wc_new;
        res_perr_nxt = (PCW + 1)'(pc_new) > (PCW + 1)'(PAGE_WRITE_LIMIT);
        res_werr_nxt = (WCW + 1)'(wc_new) > (WCW + 1)'(WORD_WRITE_LIMIT);
        if (dec_wi < WAW'(fwpc_pkg::LOCK_WORDS)) begin
          lock_nxt[{lock_row, 5'd0} +: fwpc_pkg::LOCK_ROW_W] = ~res_data_r;
        end
        state_nxt = fwpc_pkg::ST_RESPOND;
      end

      // Clear the erased page's word counts, then decode the current address.
      fwpc_pkg::ST_SWEEP: begin
        wc_we    = 1'b1;
        wc_waddr = base_r + WAW'(k_r);
        if (k_r == KW'(WORDS_PER_PAGE - 1)) begin
          dec_go    = 1'b1;
          dec_x     = cur_addr;
          act_nxt   = fwpc_pkg::ACT_NONE;
          state_nxt = fwpc_pkg::ST_DECODE;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end

      // Load the result into the output registers.
      fwpc_pkg::ST_RESPOND: begin
        out_strobe_nxt = 1'b1;
        out_cmd_nxt    = res_cmd_r;
        out_addr_nxt   = res_addr_r;
        out_data_nxt   = res_data_r;
        out_ep_nxt     = res_ep_r;
        out_perr_nxt   = res_perr_r;
        out_werr_nxt   = res_werr_r;
        out_ref_nxt    = res_ref_r;
        out_lock_nxt   = lock_r[fwpc_pkg::LOCK_IDX_W'(dec_page)];
        out_bh_nxt     = bcnt_r;
        state_nxt      = fwpc_pkg::ST_IDLE;
      end

      default: state_nxt = fwpc_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fwpc_pkg::ST_CLEAR;
      act_r        <= fwpc_pkg::ACT_NONE;
      addr_hi_r    <= '0;
      addr_lo_r    <= '0;
      wmode_r      <= 1'b0;
      bcnt_r       <= '0;
      lock_r       <= '0;
      clr_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      act_r        <= act_nxt;
      addr_hi_r    <= addr_hi_nxt;
      addr_lo_r    <= addr_lo_nxt;
      wmode_r      <= wmode_nxt;
      bcnt_r       <= bcnt_nxt;
      lock_r       <= lock_nxt;
      clr_r        <= clr_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    gather_r   <= gather_nxt;
    base_r     <= base_nxt;
    k_r        <= k_nxt;
    res_cmd_r  <= res_cmd_nxt;
    res_addr_r <= res_addr_nxt;
    res_data_r <= res_data_nxt;
    res_ep_r   <= res_ep_nxt;
    res_perr_r <= res_perr_nxt;
    res_werr_r <= res_werr_nxt;
    res_ref_r  <= res_ref_nxt;
    out_cmd_r  <= out_cmd_nxt;
    out_addr_r <= out_addr_nxt;
    out_data_r <= out_data_nxt;
    out_ep_r   <= out_ep_nxt;
    out_perr_r <= out_perr_nxt;
    out_werr_r <= out_werr_nxt;
    out_ref_r  <= out_ref_nxt;
    out_lock_r <= out_lock_nxt;
    out_bh_r   <= out_bh_nxt;
  end

  assign out_strobe           = out_strobe_r;
  assign out_command          = out_cmd_r;
  assign out_word_address     = out_addr_r;
  assign out_word_data        = out_data_r;
  assign out_erase_page       = out_ep_r;
  assign out_page_limit_error = out_perr_r;
  assign out_word_limit_error = out_werr_r;
  assign out_write_refused    = out_ref_r;
  assign out_page_locked      = out_lock_r;
  assign out_bytes_held       = out_bh_r;

  // The block is busy in the cycle after any reset cycle.
  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low after reset");

  // A decode result only arrives while the sequencer waits for it.
  a_decode_expected: assert property (@(posedge clk) disable iff (!rst_n)
    dec_done |-> state_r == fwpc_pkg::ST_DECODE)
    else $error("decode finished outside the decode wait");

  // Each beat gives a single one-cycle result.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  // A program result leaves no bytes gathered.
  a_program_empties: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_command == fwpc_pkg::CMD_PROGRAM |-> out_bytes_held == 2'd0)
    else $error("bytes held after a word program");

  // Limit flags only come with a program.
  a_flags_on_program: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_command != fwpc_pkg::CMD_PROGRAM
      |-> !out_page_limit_error && !out_word_limit_error)
    else $error("limit flag without a program");

endmodule

>>> sim/testbench.sv
// Self-checking bench for flash_word_program_controller_unit, the flash register block.
// Register writes go in through start/busy; each result beat is checked against a local
// model of the address, gather, write-count and page-lock state. Depends on fwpc_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGES            = 128;
  localparam int WORDS_PER_PAGE   = 512;
  localparam int PAGE_WRITE_LIMIT = 1024;
  localparam int WORD_WRITE_LIMIT = 8;

  localparam int CLK_PERIOD     = 10;
  // The clearing pass after reset is the longest quiet stretch of a good run.
  localparam int WATCHDOG_LIMIT = 4 * PAGES * WORDS_PER_PAGE;
  localparam int DRAIN_CYCLES   = 32;
  localparam int REPORT_LIMIT   = 10;
  localparam int WEAR_WORDS     = 17;

  localparam logic [7:0] CTRL_OFF            = 8'h00;
  localparam logic [7:0] CTRL_ERASE          = 8'(1 << fwpc_pkg::CTRL_ERASE_BIT);
  localparam logic [7:0] CTRL_WRITE_ON       = 8'(1 << fwpc_pkg::CTRL_WEN_BIT);
  localparam logic [7:0] CTRL_ERASE_WRITE_ON = CTRL_ERASE | CTRL_WRITE_ON;

  // Addresses that get programmed often enough to trip the word limit.
  localparam logic [15:0] HOT_ADDR_A   = 16'h5A03;
  localparam logic [15:0] HOT_ADDR_B   = 16'hC1F0;
  localparam logic [7:0]  WEAR_ADDR_HI = 8'h0A;
  localparam logic [7:0]  WEAR_ADDR_LO = 8'h37;

  typedef struct packed {
    logic [1:0]                   command;
    logic [fwpc_pkg::ADDR_W-1:0]  word_address;
    logic [fwpc_pkg::WORD_W-1:0]  word_data;
    logic [fwpc_pkg::EPAGE_W-1:0] erase_page;
    logic                         page_limit_error;
    logic                         word_limit_error;
    logic                         write_refused;
    logic                         page_locked;
    logic [1:0]                   bytes_held;
  } flash_result_t;

  typedef struct packed {
    logic [1:0]    op;
    logic [7:0]    data;
    logic          pinned;
    flash_result_t want;
  } directed_beat_t;

  localparam flash_result_t CALCULATED = '0;

  // Directed writes; pinned rows carry a result that is obvious from the spec.
  directed_beat_t directed_beats [25] = '{
    '{fwpc_pkg::OP_DATA, 8'hA5, 1'b1,
      '{command: fwpc_pkg::CMD_NONE, write_refused: 1'b1, default: '0}},
    '{fwpc_pkg::OP_ADDR_HI, 8'hFF, 1'b1, '0},
    '{fwpc_pkg::OP_ADDR_LO, 8'hFF, 1'b1, '0},
    '{fwpc_pkg::OP_CTRL, CTRL_ERASE_WRITE_ON, 1'b1,
      '{command: fwpc_pkg::CMD_ERASE, erase_page: 7'h7F, default: '0}},
    '{fwpc_pkg::OP_DATA, 8'h00, 1'b0, CALCULATED},
    '{fwpc_pkg::OP_DATA, 8'hFF, 1'b0, CALCULATED},
    '{fwpc_pkg::OP_DATA, 8'h00, 1'b0, CALCULATED},
    '{fwpc_pkg::OP_DATA, 8'hFF, 1'b1,
      '{command: fwpc_pkg::CMD_PROGRAM, word_address: 16'hFFFF, word_data: 32'hFF00FF00,
        default: '0}},
    '{fwpc_pkg::OP_DATA, 8'h11, 1'b0, CALCULATED},
    '{fwpc_pkg::OP_ADDR_HI, 8'h00, 1'b0, CALCULATED},
    '{fwpc_pkg::OP_ADDR_LO, 8'h00, 1'b0, CALCULATED},
    '{fwpc_pkg::OP_CTRL, CTRL_WRITE_ON, 1'b0, CALCULATED},
    '{fwpc_pkg::OP_CTRL, CTRL_OFF, 1'b0, CALCULATED},
    '{fwpc_pkg::OP_DATA, 8'h22, 1'b1,
      '{write_refused: 1'b1, bytes_held: 2'd1, default: '0}},
    '{fwpc_pkg::OP_CTRL, CTRL_WRITE_ON, 1'b0, CALCULATED},
    '{fwpc_pkg::OP_DATA, 8'h00, 1'b0, CALCULATED},
    '{fwpc_pkg::OP_DATA, 8'h00, 1'b0, CALCULATED},
    '{fwpc_pkg::OP_DATA, 8'h00, 1'b0, CALCULATED},
    '{fwpc_pkg::OP_ADDR_LO, 8'h03, 1'b0, CALCULATED},
    '{fwpc_pkg::OP_DATA, 8'h00, 1'b0, CALCULATED},
    '{fwpc_pkg::OP_DATA, 8'h00, 1'b0, CALCULATED},
    '{fwpc_pkg::OP_DATA, 8'h00, 1'b0, CALCULATED},
    '{fwpc_pkg::OP_DATA, 8'h00, 1'b0, CALCULATED},
    '{fwpc_pkg::OP_CTRL, CTRL_ERASE, 1'b1,
      '{command: fwpc_pkg::CMD_ERASE, page_locked: 1'b1, default: '0}},
    '{fwpc_pkg::OP_DATA, 8'hFF, 1'b1,
      '{write_refused: 1'b1, page_locked: 1'b1, default: '0}}
  };

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        start        = 1'b0;
  logic [1:0]  in_operation = '0;
  logic [7:0]  in_data_byte = '0;
  logic        busy;
  logic        out_strobe;
  logic [1:0]  out_command;
  logic [15:0] out_word_address;
  logic [31:0] out_word_data;
  logic [6:0]  out_erase_page;
  logic        out_page_limit_error;
  logic        out_word_limit_error;
  logic        out_write_refused;
  logic        out_page_locked;
  logic [1:0]  out_bytes_held;

  // Local copy of the register block state.
  logic [7:0]                      reg_addr_hi;
  logic [7:0]                      reg_addr_lo;
  logic                            write_on;
  logic [1:0]                      held_bytes;
  logic [fwpc_pkg::WORD_W-1:0]     gathered;
  logic [fwpc_pkg::PAGE_CNT_W-1:0] page_wear [PAGES];
  logic [fwpc_pkg::WORD_CNT_W-1:0] word_wear [PAGES * WORDS_PER_PAGE];
  logic                            lock_bits [PAGES];

  flash_result_t pending_results [$];

  int idle_pct        = 0;
  int beats_sent      = 0;
  int results_seen    = 0;
  int mismatch_count  = 0;
  int quiet_cycles    = 0;
  int programs_seen   = 0;
  int erases_seen     = 0;
  int refused_seen    = 0;
  int page_flags_seen = 0;
  int word_flags_seen = 0;
  int locked_seen     = 0;

  flash_word_program_controller_unit #(
    .PAGES           (PAGES),
    .WORDS_PER_PAGE  (WORDS_PER_PAGE),
    .PAGE_WRITE_LIMIT(PAGE_WRITE_LIMIT),
    .WORD_WRITE_LIMIT(WORD_WRITE_LIMIT)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_data_byte        (in_data_byte),
    .out_strobe          (out_strobe),
    .out_command         (out_command),
    .out_word_address    (out_word_address),
    .out_word_data       (out_word_data),
    .out_erase_page      (out_erase_page),
    .out_page_limit_error(out_page_limit_error),
    .out_word_limit_error(out_word_limit_error),
    .out_write_refused   (out_write_refused),
    .out_page_locked     (out_page_locked),
    .out_bytes_held      (out_bytes_held)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Applies one register write to the local state and returns the result it causes.
  function automatic flash_result_t predict_register_write(logic [1:0] op,
                                                           logic [7:0] value);
    flash_result_t r;
    logic [15:0]   addr;
    int            page;
    int            word;
    int            slot;
    int            w;
    int            lock_idx;
    r = '0;
    case (op)
      fwpc_pkg::OP_ADDR_HI: reg_addr_hi = value;
      fwpc_pkg::OP_ADDR_LO: reg_addr_lo = value;
      fwpc_pkg::OP_CTRL: begin
        // An erase clears the counts of the page named by the high byte.
        if (value[fwpc_pkg::CTRL_ERASE_BIT]) begin
          r.command    = fwpc_pkg::CMD_ERASE;
          r.erase_page = reg_addr_hi[7:1];
          page = int'(reg_addr_hi[7:1]) % PAGES;
          page_wear[page] = '0;
          for (w = 0; w < WORDS_PER_PAGE; w++) begin
            word_wear[page * WORDS_PER_PAGE + w] = '0;
          end
        end
        write_on = value[fwpc_pkg::CTRL_WEN_BIT];
      end
      fwpc_pkg::OP_DATA: begin
        if (!write_on) begin
          r.write_refused = 1'b1;
        end else begin
          if (held_bytes == 2'd0) begin
            gathered = '0;
          end
          gathered = gathered | (fwpc_pkg::WORD_W'(value) << (8 * held_bytes));
          if (held_bytes != fwpc_pkg::LAST_BYTE) begin
            held_bytes = held_bytes + 2'd1;
          end else begin
            // Fourth byte: program the word and bump both saturating counts.
            held_bytes = 2'd0;
            addr = {reg_addr_hi, reg_addr_lo};
            page = (int'(addr) / WORDS_PER_PAGE) % PAGES;
            word = int'(addr) % WORDS_PER_PAGE;
            slot = page * WORDS_PER_PAGE + word;
            if (page_wear[page] != fwpc_pkg::PAGE_CNT_MAX) begin
              page_wear[page] = page_wear[page] + 1'b1;
            end
            if (word_wear[slot] != fwpc_pkg::WORD_CNT_MAX) begin
              word_wear[slot] = word_wear[slot] + 1'b1;
            end
            // The first words of page 0 hold the lock bits, a zero data bit locks.
            if (page == 0 && word < fwpc_pkg::LOCK_WORDS) begin
              for (w = 0; w < fwpc_pkg::LOCK_ROW_W; w++) begin
                lock_idx = (fwpc_pkg::LOCK_WORDS - 1 - word) * fwpc_pkg::LOCK_ROW_W + w;
                if (lock_idx < PAGES) begin
                  lock_bits[lock_idx] = ~gathered[w];
                end
              end
            end
            r.command          = fwpc_pkg::CMD_PROGRAM;
            r.word_address     = addr;
            r.word_data        = gathered;
            r.page_limit_error = int'(page_wear[page]) > PAGE_WRITE_LIMIT;
            r.word_limit_error = int'(word_wear[slot]) > WORD_WRITE_LIMIT;
            gathered = '0;
          end
        end
      end
    endcase
    addr = {reg_addr_hi, reg_addr_lo};
    r.page_locked = lock_bits[(int'(addr) / WORDS_PER_PAGE) % PAGES];
    r.bytes_held  = held_bytes;
    return r;
  endfunction

  function automatic string fmt_result(flash_result_t r);
    return $sformatf({"cmd %0d addr %h data %h epage %0d plim %b wlim %b ",
                      "ref %b lock %b held %0d"},
                     r.command, r.word_address, r.word_data, r.erase_page,
                     r.page_limit_error, r.word_limit_error, r.write_refused,
                     r.page_locked, r.bytes_held);
  endfunction

  // Presents one beat, waits for the handshake, then books the expected result.
  task automatic write_register(input logic [1:0] op, input logic [7:0] value,
                                input logic pinned = 1'b0,
                                input flash_result_t pinned_want = '0);
    flash_result_t want;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_data_byte <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = predict_register_write(op, value);
    pending_results.push_back(pinned ? pinned_want : want);
    beats_sent++;
  endtask

  // Mostly complete word programs with random content, plus erases and random noise.
  task automatic random_traffic(input int beats, input int idle);
    logic [15:0] addr;
    logic [7:0]  ctrl;
    int          target;
    int          kind;
    int          pick;
    int          k;
    idle_pct = idle;
    target   = beats_sent + beats;
    while (beats_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        pick = $urandom_range(99);
        if (pick < 25) begin
          addr = 16'($urandom_range(fwpc_pkg::LOCK_WORDS - 1));
        end else if (pick < 60) begin
          addr = pick[0] ? HOT_ADDR_A : HOT_ADDR_B;
        end else begin
          addr = 16'($urandom);
        end
        write_register(fwpc_pkg::OP_ADDR_HI, addr[15:8]);
        write_register(fwpc_pkg::OP_ADDR_LO, addr[7:0]);
        if (!write_on || $urandom_range(4) == 0) begin
          ctrl = 8'($urandom);
          ctrl[fwpc_pkg::CTRL_ERASE_BIT] = 1'b0;
          ctrl[fwpc_pkg::CTRL_WEN_BIT]   = 1'b1;
          write_register(fwpc_pkg::OP_CTRL, ctrl);
        end
        for (k = 0; k < 4; k++) begin
          // Now and then the address moves or write mode drops mid-word.
          if ($urandom_range(19) == 0) begin
            write_register(fwpc_pkg::OP_ADDR_LO, 8'($urandom));
          end
          if ($urandom_range(24) == 0) begin
            write_register(fwpc_pkg::OP_CTRL, CTRL_OFF);
            write_register(fwpc_pkg::OP_DATA, 8'($urandom));
            write_register(fwpc_pkg::OP_CTRL, CTRL_WRITE_ON);
          end
          write_register(fwpc_pkg::OP_DATA, 8'($urandom));
        end
      end else if (kind < 77) begin
        ctrl = 8'($urandom);
        ctrl[fwpc_pkg::CTRL_ERASE_BIT] = 1'b1;
        write_register(fwpc_pkg::OP_ADDR_HI, 8'($urandom));
        write_register(fwpc_pkg::OP_CTRL, ctrl);
      end else begin
        repeat ($urandom_range(1, 4)) write_register(2'($urandom), 8'($urandom));
      end
    end
  endtask

  // Result checker: every strobe beat must match the oldest booked result.
  always @(posedge clk) begin : result_check
    flash_result_t got;
    flash_result_t want;
    if (rst_n && out_strobe === 1'b1) begin
      got = '{out_command, out_word_address, out_word_data, out_erase_page,
              out_page_limit_error, out_word_limit_error, out_write_refused,
              out_page_locked, out_bytes_held};
      results_seen++;
      if (got.command == fwpc_pkg::CMD_PROGRAM) programs_seen++;
      if (got.command == fwpc_pkg::CMD_ERASE) erases_seen++;
      if (got.write_refused) refused_seen++;
      if (got.page_limit_error) page_flags_seen++;
      if (got.word_limit_error) word_flags_seen++;
      if (got.page_locked) locked_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("[%0t] Result with nothing pending: %s", $realtime, fmt_result(got));
        end
      end else begin
        want = pending_results.pop_front();
        if (got.command !== want.command || got.word_address !== want.word_address ||
            got.word_data !== want.word_data || got.erase_page !== want.erase_page ||
            got.page_limit_error !== want.page_limit_error ||
            got.word_limit_error !== want.word_limit_error ||
            got.write_refused !== want.write_refused ||
            got.page_locked !== want.page_locked ||
            got.bytes_held !== want.bytes_held) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] Mismatch on result %0d", $realtime, results_seen);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(got));
          end
        end
      end
    end
  end

  // Watchdog: ends the run if no beat moves either way for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d quiet cycles, %0d results pending",
               quiet_cycles, pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int n;
    reg_addr_hi = '0;
    reg_addr_lo = '0;
    write_on    = 1'b0;
    held_bytes  = '0;
    gathered    = '0;
    foreach (page_wear[i]) page_wear[i] = '0;
    foreach (word_wear[i]) word_wear[i] = '0;
    foreach (lock_bits[i]) lock_bits[i] = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners at full rate.
    idle_pct = 0;
    foreach (directed_beats[i]) begin
      write_register(directed_beats[i].op, directed_beats[i].data,
                     directed_beats[i].pinned, directed_beats[i].want);
    end

    // Random traffic under different sender gap rates.
    random_traffic(160, 0);
    random_traffic(160, 72);
    random_traffic(160, 38);

    // Program one word past its limit into saturation, then erase its page and program again.
    idle_pct = 0;
    write_register(fwpc_pkg::OP_ADDR_HI, WEAR_ADDR_HI);
    write_register(fwpc_pkg::OP_ADDR_LO, WEAR_ADDR_LO);
    write_register(fwpc_pkg::OP_CTRL, CTRL_WRITE_ON);
    for (n = 0; n < WEAR_WORDS; n++) begin
      repeat (4) write_register(fwpc_pkg::OP_DATA, 8'($urandom));
    end
    write_register(fwpc_pkg::OP_CTRL, CTRL_ERASE_WRITE_ON);
    repeat (4) write_register(fwpc_pkg::OP_DATA, 8'($urandom));
    start <= 1'b0;

    // Drain, then give stray beats a chance to show.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d register writes: %0d word programs, %0d page erases, %0d refused bytes.",
             beats_sent, programs_seen, erases_seen, refused_seen);
    $display("Page limit flagged %0d times, word limit %0d times, locked page %0d; %0d mismatches.",
             page_flags_seen, word_flags_seen, locked_seen, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
